/* rtl/lru_key_value_cache_defines.svh */
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property shorthands; the using scope provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define LKV_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define LKV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Index and rank fields on the inter-cell wires cover the largest capacity (256).
  localparam int MaxIdxW = 8;

  typedef logic [MaxIdxW-1:0] idx_t;
  typedef logic [MaxIdxW-1:0] rank_t;

  localparam int DataW = 32;

  localparam logic [DataW-1:0] MissValue  = '1;   // lookup miss reads -1
  localparam logic [DataW-1:0] WriteValue = '0;   // writes read back 0

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  // Search token passed cell to cell; each cell folds in its own entry.
  typedef struct packed {
    logic             active;
    logic             hit;
    idx_t             hit_idx;
    rank_t            hit_rank;
    logic [DataW-1:0] hit_value;
    logic             free_ok;
    idx_t             free_idx;
    logic             lru_ok;
    idx_t             lru_idx;
    rank_t            lru_rank;
  } scan_t;

  // Update broadcast to every cell for one cycle.
  typedef struct packed {
    logic             en;
    logic             touch;
    logic             wr_value;
    logic             insert;
    logic             evict;
    idx_t             tgt_idx;
    rank_t            ref_rank;
    idx_t             ev_idx;
    rank_t            ev_rank;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } upd_t;

endpackage

/* rtl/lkv_cell.sv */
// ----------------------------------------------------------------------------
// lkv_cell
// One cache entry: valid, key, value, recency rank, plus one stage of the
// search token chain.
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int CellIdx = 0,
  parameter int RankW   = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lkv_pkg::DataW-1:0]      key_i,
  input  lkv_pkg::upd_t                  cmd_i,
  input  lkv_pkg::scan_t                 tok_i,
  output lkv_pkg::scan_t                 tok_o,
  output logic                           valid_o
);

  localparam lkv_pkg::idx_t MyIdx = lkv_pkg::idx_t'(CellIdx);

  logic                      valid_q, valid_d;
  logic [lkv_pkg::DataW-1:0] key_q, key_d;
  logic [lkv_pkg::DataW-1:0] val_q, val_d;
  logic [RankW-1:0]          rank_q, rank_d;
  lkv_pkg::scan_t            tok_q, tok_d;
  lkv_pkg::rank_t            rank_w;
  logic                      is_tgt, is_ev;

  assign rank_w = lkv_pkg::rank_t'(rank_q);
  assign is_tgt = (cmd_i.tgt_idx == MyIdx);
  assign is_ev  = (cmd_i.ev_idx == MyIdx);

  // search stage
  always_comb begin
    tok_d = tok_i;
    if (tok_i.active) begin
      if (valid_q && (key_q == key_i) && !tok_i.hit) begin
        tok_d.hit       = 1'b1;
        tok_d.hit_idx   = MyIdx;
        tok_d.hit_rank  = rank_w;
        tok_d.hit_value = val_q;
      end
      if (!valid_q && !tok_i.free_ok) begin
        tok_d.free_ok  = 1'b1;
        tok_d.free_idx = MyIdx;
      end
      if (valid_q && (!tok_i.lru_ok || (rank_w > tok_i.lru_rank))) begin
        tok_d.lru_ok   = 1'b1;
        tok_d.lru_idx  = MyIdx;
        tok_d.lru_rank = rank_w;
      end
    end
  end

  // entry update
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    rank_d  = rank_q;
    if (cmd_i.en) begin
      if (cmd_i.touch) begin
        if (is_tgt) begin
          rank_d = '0;
          if (cmd_i.wr_value) begin
            val_d = cmd_i.value;
          end
        end else if (valid_q && (rank_w < cmd_i.ref_rank)) begin
          rank_d = RankW'(rank_q + 1'b1);
        end
      end else if (cmd_i.insert) begin
        if (is_tgt) begin
          valid_d = 1'b1;
          key_d   = cmd_i.key;
          val_d   = cmd_i.value;
          rank_d  = '0;
        end else if (cmd_i.evict && is_ev) begin
          valid_d = 1'b0;
        end else if (valid_q && !(cmd_i.evict && (rank_w > cmd_i.ev_rank))) begin
          // other valid entries move back; behind the evicted entry -1 then +1 cancel
          rank_d = RankW'(rank_q + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    rank_q <= rank_d;
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

/* rtl/lru_key_value_cache.sv */
// Flow: an accepted word is registered, then its search token walks the cell chain,
//   one cell per cycle, and the update is applied to all cells at once when the result
//   register is free or being drained; no new word is accepted until then.
// Reset: all entries invalid, occupancy 0, capacity_in_use 16; no clearing pass.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement,
// built as a chain of entry cells with per-entry recency ranks.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_op_i,
  input  logic signed [31:0] in_key_i,
  input  logic signed [31:0] in_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_hit_o,
  output logic signed [31:0] out_read_value_o,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Rank field width per cell; occupancy counts 0..CAPACITY.
  localparam int RankW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OccW  = $clog2(CAPACITY + 1);
  localparam int CapW  = 5;
  localparam int CmpW  = (OccW > CapW) ? OccW : CapW;

  localparam logic [2:0] RegCapacityAddr = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e                    state_q;
  logic [CapW-1:0]           cap_q;
  logic [OccW-1:0]           occ_q, occ_d;
  logic                      launch_q;
  lkv_pkg::scan_t            tok_q;
  logic                      out_valid_q, out_hit_q;
  logic [lkv_pkg::DataW-1:0] out_value_q;

  // request word held for the whole search/apply
  lkv_pkg::op_e              req_op_q;
  logic [lkv_pkg::DataW-1:0] req_key_q, req_value_q;

  lkv_pkg::scan_t            tok [CAPACITY+1];
  logic [CAPACITY-1:0]       valid_vec;
  lkv_pkg::upd_t             cmd;

  logic                      in_accept, cfg_write, apply_go;
  logic                      is_write, full, do_evict, do_insert;
  logic [CmpW-1:0]           eff_limit;
  lkv_pkg::idx_t             slot;
  logic [lkv_pkg::DataW-1:0] result_value;

  // --------------------------------------------------------------------------
  // Config port: single register, zero wait states.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == RegCapacityAddr);
  assign prdata    = (paddr == RegCapacityAddr) ? {{(32-CapW){1'b0}}, cap_q} : '0;

  // --------------------------------------------------------------------------
  // Handshakes. New words only enter when the chain is free.
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // apply only when the result register is free or being drained
  assign apply_go   = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // Cell chain. Token enters cell 0 in the cycle after accept (key is registered
  // by then) and passes through the token register of each cell in turn.
  // --------------------------------------------------------------------------
  always_comb begin
    tok[0]        = '0;
    tok[0].active = launch_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lkv_cell #(
      .CellIdx (g),
      .RankW   (RankW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (req_key_q),
      .cmd_i   (cmd),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .valid_o (valid_vec[g])
    );
  end

  // --------------------------------------------------------------------------
  // Update decision from the finished token.
  // Effective limit is capacity_in_use clamped to 1..CAPACITY.
  // --------------------------------------------------------------------------
  always_comb begin
    if (cap_q == '0) begin
      eff_limit = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(CAPACITY)) begin
      eff_limit = CmpW'(CAPACITY);
    end else begin
      eff_limit = CmpW'(cap_q);
    end
  end

  assign is_write  = (req_op_q == lkv_pkg::OP_WRITE);
  assign full      = (CmpW'(occ_q) >= eff_limit);
  assign do_evict  = is_write && !tok_q.hit && full && tok_q.lru_ok;
  assign do_insert = is_write && !tok_q.hit && (do_evict || tok_q.free_ok);

  // After an eviction the lowest free slot is the lower of the two.
  always_comb begin
    if (do_evict && !(tok_q.free_ok && (tok_q.free_idx < tok_q.lru_idx))) begin
      slot = tok_q.lru_idx;
    end else begin
      slot = tok_q.free_idx;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.en       = apply_go;
    cmd.touch    = tok_q.hit;
    cmd.wr_value = tok_q.hit && is_write;
    cmd.insert   = do_insert;
    cmd.evict    = do_evict;
    cmd.tgt_idx  = tok_q.hit ? tok_q.hit_idx : slot;
    cmd.ref_rank = tok_q.hit_rank;
    cmd.ev_idx   = tok_q.lru_idx;
    cmd.ev_rank  = tok_q.lru_rank;
    cmd.key      = req_key_q;
    cmd.value    = req_value_q;
  end

  always_comb begin
    occ_d = occ_q;
    if (do_insert && !do_evict) begin
      occ_d = OccW'(occ_q + 1'b1);
    end else if (do_evict && !do_insert) begin
      occ_d = OccW'(occ_q - 1'b1);
    end
  end

  always_comb begin
    if (is_write) begin
      result_value = lkv_pkg::WriteValue;
    end else if (tok_q.hit) begin
      result_value = tok_q.hit_value;
    end else begin
      result_value = lkv_pkg::MissValue;
    end
  end

  // --------------------------------------------------------------------------
  // Control FSM and registered outputs.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapW'(16);
      occ_q       <= '0;
      launch_q    <= 1'b0;
      tok_q       <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_value_q <= '0;
    end else begin
      launch_q <= in_accept;
      if (cfg_write) begin
        cap_q <= pwdata[CapW-1:0];
      end
      // result register: load on apply, clear once the word is taken
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok[CAPACITY].active) begin
            tok_q   <= tok[CAPACITY];
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply_go) begin
            occ_q       <= occ_d;
            out_hit_q   <= tok_q.hit;
            out_value_q <= result_value;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_op_q    <= lkv_pkg::op_e'(in_op_i);
      req_key_q   <= in_key_i;
      req_value_q <= in_value_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_read_value_o = out_value_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LKV_ASSERT_IMPL(a_occ_matches_valid, 1'b1, $countones(valid_vec) == int'(occ_q), "occupancy out of step with valid bits")
  `LKV_ASSERT_IMPL(a_token_only_in_scan, tok[CAPACITY].active, state_q == ST_SCAN, "token left chain outside scan")
  `LKV_ASSERT_IMPL(a_lru_found, tok[CAPACITY].active && (occ_q != '0), tok[CAPACITY].lru_ok, "no LRU entry in non-empty cache")
  `LKV_ASSERT_NEXT(a_apply_loads_out, apply_go, out_valid_o && (state_q == ST_IDLE), "apply did not produce a result word")

endmodule
